@@ rtl/core/qoi_enc_pkg.sv @@
// ----------------------------------------------------------------------------
// QOI encoder package
// Pixel type, chunk opcodes, index hash and register map used by the
// encoder core.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_enc_pkg;

  // Packed so that bits [7:0] hold red and bits [31:24] hold alpha.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  localparam int PIXEL_BITS    = 32;
  localparam int INDEX_ENTRIES = 64;
  localparam int INDEX_BITS    = 6;
  localparam int MAX_RUN       = 62;
  localparam int MAX_BYTES     = 6;
  localparam int CHUNK_BYTES   = 5;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  // Register index (byte address bit 2)
  localparam logic REG_WITH_ALPHA = 1'b0;

  localparam pixel_t PIXEL_START = '{a: 8'hFF, b: 8'h00, g: 8'h00, r: 8'h00};

  // (3r + 5g + 7b + 11a) mod 64; only the low six bits of each channel matter.
  function automatic logic [INDEX_BITS-1:0] pixel_hash(pixel_t p);
    logic [INDEX_BITS-1:0] sum;
    sum = p.r[INDEX_BITS-1:0] * 6'd3 + p.g[INDEX_BITS-1:0] * 6'd5
        + p.b[INDEX_BITS-1:0] * 6'd7 + p.a[INDEX_BITS-1:0] * 6'd11;
    return sum;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/qoi_pixel_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// QOI pixel encoder
// Flow: a pixel waits in the input register until the result register is free, then is
//   encoded into it and its first byte offered; repeats that only extend a run skip it.
// Throughput: one pixel per cycle while each pixel yields at most one byte and the
//   output is not stalled; longer chunks hold the output until their last byte is taken.
// Reset (rst, synchronous): empty the pipeline, clear index valid bits and run, set the
//   previous pixel to the start pixel and with_alpha to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_pixel_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Pixel stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  wire logic        s_axis_tuser,   // first_pixel
  input  wire logic        s_axis_tlast,   // last_pixel
  // Chunk byte stream out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic             m_axis_tlast,   // last_byte
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IB = qoi_enc_pkg::INDEX_BITS;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic with_alpha;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      with_alpha <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == qoi_enc_pkg::REG_WITH_ALPHA)) begin
      with_alpha <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == qoi_enc_pkg::REG_WITH_ALPHA) ? {31'd0, with_alpha} : 32'd0;

  // --------------------------------------------------------------------------
  // Input side: force alpha, hash the pixel and start the index read
  // --------------------------------------------------------------------------
  qoi_enc_pkg::pixel_t in_px;
  logic [IB-1:0]       in_hash;
  logic                in_fire;

  always_comb begin
    in_px.r = s_axis_tdata[7:0];
    in_px.g = s_axis_tdata[15:8];
    in_px.b = s_axis_tdata[23:16];
    in_px.a = with_alpha ? s_axis_tdata[31:24] : 8'hFF;
  end

  assign in_hash = qoi_enc_pkg::pixel_hash(in_px);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Input register stage
  logic                s1_valid;
  qoi_enc_pkg::pixel_t s1_px;
  logic [IB-1:0]       s1_hash;
  logic                s1_first;
  logic                s1_last;
  logic                fwd_hit;   // index entry comes from the write in flight
  qoi_enc_pkg::pixel_t fwd_px;

  // Image state
  qoi_enc_pkg::pixel_t               prev;
  logic [5:0]                        run;
  logic [qoi_enc_pkg::INDEX_ENTRIES-1:0] idx_valid;
  logic [qoi_enc_pkg::INDEX_ENTRIES-1:0] idx_valid_next;

  // Encode results of the input stage
  logic       s1_adv;
  logic       idx_write;
  logic [2:0] s1_count;
  logic [7:0] s1_bytes [qoi_enc_pkg::MAX_BYTES];
  logic [5:0] run_next;

  // Output serializer
  logic       res_valid;
  logic [7:0] res_bytes [qoi_enc_pkg::MAX_BYTES];
  logic [2:0] res_count;
  logic [2:0] res_idx;
  logic       out_fire;
  logic       res_done;
  logic       res_free;

  // Color index memory; read address follows the incoming pixel, or holds
  // the waiting pixel's slot while the stage is stalled.
  logic [qoi_enc_pkg::PIXEL_BITS-1:0] ram_rdata;
  logic [IB-1:0]                      ram_raddr;

  assign ram_raddr = in_fire ? in_hash : s1_hash;

  qoi_enc_ram #(
    .WIDTH (qoi_enc_pkg::PIXEL_BITS),
    .DEPTH (qoi_enc_pkg::INDEX_ENTRIES)
  ) u_index_ram (
    .clk   (clk),
    .we    (s1_adv && idx_write),
    .waddr (s1_hash),
    .wdata (s1_px),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of the input stage; capture a same-slot write from the pixel
  // leaving the stage, since the memory returns the old word in that cycle.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px    <= in_px;
      s1_hash  <= in_hash;
      s1_first <= s_axis_tuser;
      s1_last  <= s_axis_tlast;
      fwd_hit  <= s1_adv && idx_write && (s1_hash == in_hash);
      fwd_px   <= s1_px;
    end
  end

  // --------------------------------------------------------------------------
  // Encode: one pass from the input register to the result register
  // --------------------------------------------------------------------------
  qoi_enc_pkg::pixel_t prev_eff;
  qoi_enc_pkg::pixel_t entry;
  logic [5:0]          run_eff;
  logic [5:0]          run_inc;
  logic                same;
  logic                hit;
  logic signed [7:0]   vr, vg, vb, vgr, vgb;
  logic                small_diff;
  logic                luma_fit;

  // A first pixel sees a cleared index, an empty run and the start pixel.
  assign prev_eff = s1_first ? qoi_enc_pkg::PIXEL_START : prev;
  assign run_eff  = s1_first ? 6'd0 : run;
  assign run_inc  = run_eff + 6'd1;
  assign entry    = (!s1_first && idx_valid[s1_hash])
                    ? (fwd_hit ? fwd_px : qoi_enc_pkg::pixel_t'(ram_rdata))
                    : qoi_enc_pkg::pixel_t'('0);
  assign same     = (s1_px == prev_eff);
  assign hit      = (entry == s1_px);

  // Channel differences wrap modulo 256
  assign vr  = s1_px.r - prev_eff.r;
  assign vg  = s1_px.g - prev_eff.g;
  assign vb  = s1_px.b - prev_eff.b;
  assign vgr = vr - vg;
  assign vgb = vb - vg;

  assign small_diff = (vr >= -8'sd2) && (vr <= 8'sd1) && (vg >= -8'sd2) && (vg <= 8'sd1)
                   && (vb >= -8'sd2) && (vb <= 8'sd1);
  assign luma_fit   = (vgr >= -8'sd8) && (vgr <= 8'sd7) && (vg >= -8'sd32)
                   && (vg <= 8'sd31) && (vgb >= -8'sd8) && (vgb <= 8'sd7);

  always_comb begin
    logic [7:0] chunk [qoi_enc_pkg::CHUNK_BYTES];
    logic [2:0] chunk_len;
    logic       flush;
    logic [7:0] run_byte;
    logic [7:0] dr, dg, db, lg, lr, lb;

    dr = 8'(vr + 8'sd2);
    dg = 8'(vg + 8'sd2);
    db = 8'(vb + 8'sd2);
    lg = 8'(vg + 8'sd32);
    lr = 8'(vgr + 8'sd8);
    lb = 8'(vgb + 8'sd8);

    for (int k = 0; k < qoi_enc_pkg::CHUNK_BYTES; k++) begin
      chunk[k] = 8'h00;
    end
    chunk_len = 3'd0;
    flush     = 1'b0;
    run_byte  = qoi_enc_pkg::OP_RUN | {2'b00, run_eff - 6'd1};
    run_next  = 6'd0;
    idx_write = 1'b0;

    if (same) begin
      // Extend the run; flush it when full or at the end of the image
      if ((run_inc >= 6'(qoi_enc_pkg::MAX_RUN)) || s1_last) begin
        chunk[0]  = qoi_enc_pkg::OP_RUN | {2'b00, run_eff};
        chunk_len = 3'd1;
      end else begin
        run_next = run_inc;
      end
    end else begin
      flush = (run_eff != 6'd0);
      if (hit) begin
        chunk[0]  = qoi_enc_pkg::OP_INDEX | {2'b00, s1_hash};
        chunk_len = 3'd1;
      end else begin
        idx_write = 1'b1;
        if (s1_px.a == prev_eff.a) begin
          if (small_diff) begin
            chunk[0]  = qoi_enc_pkg::OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
            chunk_len = 3'd1;
          end else if (luma_fit) begin
            chunk[0]  = qoi_enc_pkg::OP_LUMA | {2'b00, lg[5:0]};
            chunk[1]  = {lr[3:0], lb[3:0]};
            chunk_len = 3'd2;
          end else begin
            chunk[0]  = qoi_enc_pkg::OP_RGB;
            chunk[1]  = s1_px.r;
            chunk[2]  = s1_px.g;
            chunk[3]  = s1_px.b;
            chunk_len = 3'd4;
          end
        end else begin
          chunk[0]  = qoi_enc_pkg::OP_RGBA;
          chunk[1]  = s1_px.r;
          chunk[2]  = s1_px.g;
          chunk[3]  = s1_px.b;
          chunk[4]  = s1_px.a;
          chunk_len = 3'd5;
        end
      end
    end

    // Put the pending run ahead of the chunk
    if (flush) begin
      s1_bytes[0] = run_byte;
      for (int k = 1; k < qoi_enc_pkg::MAX_BYTES; k++) begin
        s1_bytes[k] = chunk[k-1];
      end
      s1_count = chunk_len + 3'd1;
    end else begin
      for (int k = 0; k < qoi_enc_pkg::CHUNK_BYTES; k++) begin
        s1_bytes[k] = chunk[k];
      end
      s1_bytes[qoi_enc_pkg::MAX_BYTES-1] = 8'h00;
      s1_count = chunk_len;
    end
  end

  // A pixel with no bytes leaves the stage without waiting for the output.
  assign s1_adv = s1_valid && ((s1_count == 3'd0) || res_free);

  // A first pixel drops every valid bit; a written slot becomes valid.
  always_comb begin
    idx_valid_next = s1_first ? '0 : idx_valid;
    if (idx_write) begin
      idx_valid_next[s1_hash] = 1'b1;
    end
  end

  // Image state advances with each encoded pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= qoi_enc_pkg::PIXEL_START;
      run       <= 6'd0;
      idx_valid <= '0;
    end else if (s1_adv) begin
      prev      <= s1_px;
      run       <= run_next;
      idx_valid <= idx_valid_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register and byte serializer
  // --------------------------------------------------------------------------
  assign out_fire = res_valid && m_axis_tready;
  assign res_done = out_fire && (res_idx == res_count - 3'd1);
  assign res_free = !res_valid || res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_count <= 3'd0;
      res_idx   <= 3'd0;
    end else if (s1_adv && (s1_count != 3'd0)) begin
      res_valid <= 1'b1;
      res_count <= s1_count;
      res_idx   <= 3'd0;
    end else if (res_done) begin
      res_valid <= 1'b0;
    end else if (out_fire) begin
      res_idx <= res_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_count != 3'd0)) begin
      res_bytes <= s1_bytes;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res_bytes[res_idx];
  assign m_axis_tlast  = (res_idx == res_count - 3'd1);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A held result always carries between one and six bytes
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_count != 3'd0) && (res_count <= 3'(qoi_enc_pkg::MAX_BYTES))))
    else $error("result register holds an invalid byte count");

  // A pending run never reaches the run limit; it is flushed at that point
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    run < 6'(qoi_enc_pkg::MAX_RUN))
    else $error("pending run reached the run limit");

  // The serializer index stays inside the held chunk
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_idx < res_count))
    else $error("serializer index past the end of the chunk");

  // Reset empties the index
  a_reset_index: assert property (@(posedge clk)
    $past(rst) |-> (idx_valid == '0))
    else $error("index valid bits not cleared by reset");

endmodule

`default_nettype wire

@@ rtl/core/qoi_enc_ram.sv @@
// ----------------------------------------------------------------------------
// QOI encoder RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_enc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
